FILE: rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, reset masked
`define UTF8D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/utf8d_pkg.sv
// Types and constants shared by the UTF-8 stream decoder modules.
// No dependencies.
package utf8d_pkg;

  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_CODE = 8'hF0;
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_CODE  = 8'h80;
  localparam logic [7:0]  ASCII_TOP  = 8'h80;
  localparam logic [7:0]  BITS2_MASK = 8'h1F;
  localparam logic [7:0]  BITS3_MASK = 8'h0F;
  localparam logic [7:0]  BITS4_MASK = 8'h07;
  localparam logic [7:0]  CONT_BITS  = 8'h3F;
  localparam logic [20:0] REPL_CP    = 21'h00FFFD;

  // one accepted byte, as the back end needs to play it out
  typedef struct packed {
    logic [1:0]  pre;      // replacements for held bytes before the main result
    logic        main_en;  // a main result follows the pre replacements
    logic        main_ok;  // main result is a decoded code point
    logic [20:0] main_cp;
    logic [2:0]  main_len;
    logic [2:0]  n_res;    // total results, 1..4
    logic        ends;
  } desc_t;

endpackage

FILE: rtl/utf8d_if.sv
// Valid/ready channel interfaces for the UTF-8 stream decoder.
// No dependencies.
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        code_valid;
  logic [2:0]  seq_length;
  logic        last_result;
  logic        text_end;
  logic        text_ok;

  modport source (output valid, code_point, code_valid, seq_length, last_result,
                  text_end, text_ok, input ready);
  modport sink   (input valid, code_point, code_valid, seq_length, last_result,
                  text_end, text_ok, output ready);
endinterface

FILE: rtl/utf8d_front.sv
// Front end: accepts bytes, tracks the pending sequence, builds one descriptor
// per byte that causes results. Depends on utf8d_pkg.
module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  input  logic              q_full,
  output logic              q_push,
  output utf8d_pkg::desc_t  q_desc
);
  import utf8d_pkg::*;

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [2:0]  total_r, total_nxt;

  logic        accept;
  logic        is_cont;
  logic [20:0] cat;
  logic [2:0]  inc;
  logic [2:0]  post;
  desc_t       d;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte & CONT_MASK) == CONT_CODE;
  assign cat      = {partial_r[14:0], in_byte[5:0]};
  assign inc      = {1'b0, held_r} + 3'd1;

  always_comb begin
    d           = '0;
    d.ends      = end_of_text;
    post        = 3'd0;
    partial_nxt = partial_r;
    held_nxt    = held_r;
    total_nxt   = total_r;
    if (held_r != 2'd0 && is_cont) begin
      if (inc >= total_r) begin
        d.main_en   = 1'b1;
        d.main_ok   = 1'b1;
        d.main_cp   = cat;
        d.main_len  = total_r;
        partial_nxt = '0;
        held_nxt    = 2'd0;
        total_nxt   = 3'd0;
      end else begin
        partial_nxt = cat;
        held_nxt    = inc[1:0];
        if (end_of_text) post = inc;
      end
    end else begin
      // a broken sequence drops its held bytes, then the byte is a new lead
      d.pre       = held_r;
      partial_nxt = '0;
      held_nxt    = 2'd0;
      total_nxt   = 3'd0;
      if (in_byte < ASCII_TOP) begin
        d.main_en  = 1'b1;
        d.main_ok  = 1'b1;
        d.main_cp  = {13'd0, in_byte};
        d.main_len = 3'd1;
      end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
        partial_nxt = {13'd0, in_byte & BITS2_MASK};
        held_nxt    = 2'd1;
        total_nxt   = 3'd2;
        if (end_of_text) post = 3'd1;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
        partial_nxt = {13'd0, in_byte & BITS3_MASK};
        held_nxt    = 2'd1;
        total_nxt   = 3'd3;
        if (end_of_text) post = 3'd1;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
        partial_nxt = {13'd0, in_byte & BITS4_MASK};
        held_nxt    = 2'd1;
        total_nxt   = 3'd4;
        if (end_of_text) post = 3'd1;
      end else begin
        d.main_en  = 1'b1;
        d.main_cp  = REPL_CP;
        d.main_len = 3'd1;
      end
    end
    if (end_of_text) begin
      partial_nxt = '0;
      held_nxt    = 2'd0;
      total_nxt   = 3'd0;
    end
    d.n_res = {1'b0, d.pre} + {2'd0, d.main_en} + post;
  end

  assign q_desc = d;
  assign q_push = accept && (d.n_res != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      held_r    <= 2'd0;
      total_r   <= 3'd0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      held_r    <= held_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

FILE: rtl/utf8d_queue.sv
// Short descriptor queue between front and back end.
// Depends on utf8d_pkg.
module utf8d_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8d_pkg::desc_t  push_desc,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output utf8d_pkg::desc_t  head
);
  import utf8d_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = count_r == FULL_CNT;
  assign not_empty = count_r != '0;
  assign head      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: rtl/utf8d_back.sv
// Back end: plays each descriptor out into the output register, one result per
// cycle unless out_ch stalls, and keeps the text validity flag. Depends on utf8d_pkg.
module utf8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  utf8d_pkg::desc_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [20:0]       code_point,
  output logic              code_valid,
  output logic [2:0]        seq_length,
  output logic              last_result,
  output logic              text_end,
  output logic              text_ok
);
  import utf8d_pkg::*;

  logic [1:0]  idx_r;
  logic        all_valid_r;
  logic        valid_r;
  logic [20:0] cp_r;
  logic        ok_r, last_r, end_r, tok_r;
  logic [2:0]  len_r;

  logic        adv, emit, is_main, is_last, res_ok;
  logic [20:0] res_cp;
  logic [2:0]  res_len;

  assign adv     = !valid_r || out_ready;
  assign emit    = adv && q_not_empty;
  assign is_last = ({1'b0, idx_r} + 3'd1) == q_head.n_res;
  assign is_main = q_head.main_en && (idx_r == q_head.pre);
  assign res_ok  = is_main && q_head.main_ok;
  assign res_cp  = is_main ? q_head.main_cp  : REPL_CP;
  assign res_len = is_main ? q_head.main_len : 3'd1;
  assign q_pop   = emit && is_last;

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r   <= res_cp;
      ok_r   <= res_ok;
      len_r  <= res_len;
      last_r <= is_last;
      end_r  <= q_head.ends;
      tok_r  <= all_valid_r && res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      idx_r       <= 2'd0;
      all_valid_r <= 1'b1;
    end else begin
      if (adv) valid_r <= q_not_empty;
      if (emit) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
        // the closing result of a text re-arms the flag for the next one
        if (is_last && q_head.ends) all_valid_r <= 1'b1;
        else if (!res_ok)           all_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = valid_r;
  assign code_point  = cp_r;
  assign code_valid  = ok_r;
  assign seq_length  = len_r;
  assign last_result = last_r;
  assign text_end    = end_r;
  assign text_ok     = tok_r;

endmodule

FILE: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder, top level.
// Channels: in_ch carries one byte of text per transfer with end_of_text on
// the last byte of a text; out_ch carries one decoded code point or U+FFFD
// replacement per transfer, with its byte count, a last-result-of-this-byte
// flag, a text-end flag and the running text validity flag.
// Decoding is lenient: overlong forms, surrogates and values above U+10FFFF
// pass as they decode. A broken sequence gives one U+FFFD per held byte.
// Each byte's descriptor is registered in the queue and each result again in the
// output register, from which it shows on out_ch.
// Throughput: one byte per cycle while each byte causes at most one result and out_ch
// does not stall; results leave one per cycle unless out_ch stalls, so a byte that
// causes more than one result holds the back end until its last is out, and the
// descriptor queue (QUEUE_DEPTH entries) lets input continue until it fills.
// Bytes that only extend a pending sequence cause no result and cost nothing
// downstream.
// Reset (rst_n low, synchronous) drops any pending sequence, empties the
// queue and output register and sets text validity to 1.
// When out_ch stalls, the output register holds its result, the queue fills,
// and then in_ch.ready drops until the receiver takes results again.
// Files: utf8d_pkg, utf8d_if, utf8d_front, utf8d_queue, utf8d_back.
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  utf8d_in_if.sink      in_ch,
  utf8d_out_if.source   out_ch
);
  import utf8d_pkg::*;

  logic  q_push, q_full, q_pop, q_not_empty;
  desc_t q_desc, q_head;

  utf8d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_desc      (q_desc)
  );

  utf8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  utf8d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .code_point  (out_ch.code_point),
    .code_valid  (out_ch.code_valid),
    .seq_length  (out_ch.seq_length),
    .last_result (out_ch.last_result),
    .text_end    (out_ch.text_end),
    .text_ok     (out_ch.text_ok)
  );

endmodule

FILE: rtl/utf8d_checker.sv
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8_stream_decoder_assert.svh.
`include "utf8_stream_decoder_assert.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic        code_valid,
  input logic [2:0]  seq_length,
  input logic        text_ok
);

  `UTF8D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(code_valid) && $stable(seq_length), "stalled result changed")

  `UTF8D_ASSERT_NOW(a_repl_form, out_valid && !code_valid, code_point == 21'h00FFFD && seq_length == 3'd1, "malformed replacement")

  // payload bits available for each length bound the code point
  `UTF8D_ASSERT_NOW(a_cp_range, out_valid && code_valid, (seq_length == 3'd1 && code_point < 21'h80) || (seq_length == 3'd2 && code_point < 21'h800) || (seq_length == 3'd3 && code_point < 21'h10000) || seq_length == 3'd4, "code point does not fit length")

  `UTF8D_ASSERT_NOW(a_repl_clears_ok, out_valid && !code_valid, !text_ok, "replacement left text_ok set")

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .code_point (out_ch.code_point),
  .code_valid (out_ch.code_valid),
  .seq_length (out_ch.seq_length),
  .text_ok    (out_ch.text_ok)
);

FILE: test/utf8_stream_decoder_tb.sv
// Self-checking testbench for utf8_stream_decoder: directed and random UTF-8 texts.
// A scoreboard class predicts every result and checks the output channel.
// Depends on utf8d_pkg, utf8d_if and the decoder RTL.
module utf8_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int RANDOM_BYTES = 430;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [20:0] code_point;
    logic        code_valid;
    logic [2:0]  seq_length;
    logic        last_result;
    logic        text_end;
    logic        text_ok;
  } utf8_result_t;

  // {end_of_text, byte}
  localparam logic [8:0] DIRECTED [24] = '{
    9'h000, 9'h07F,                  // ASCII extremes
    9'h0C2, 9'h0A9,                  // two-byte
    9'h0E2, 9'h082, 9'h0AC,          // three-byte
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,  // four-byte, largest code point
    9'h0ED, 9'h0A0, 9'h080,          // surrogate passes
    9'h080, 9'h0FF,                  // stray bytes in lead position
    9'h0E2, 9'h082, 9'h041,          // broken sequence, ASCII decoded after
    9'h0F0, 9'h090, 9'h0BF,          // three bytes held ...
    9'h1E0,                          // ... lead on the last byte: four replacements
    9'h141                           // next text starts clean
  };

  class utf8_scoreboard;
    logic [20:0]  partial_bits;
    logic [2:0]   held_cnt;
    logic [2:0]   seq_len;
    logic         text_valid;
    utf8_result_t byte_results[$];
    utf8_result_t expected_q[$];
    int unsigned  failures;

    function new();
      partial_bits = '0;
      held_cnt     = '0;
      seq_len      = '0;
      text_valid   = 1'b1;
      failures     = 0;
    endfunction

    function void emit(logic [20:0] cp, logic ok, logic [2:0] len, logic ends);
      utf8_result_t r;
      if (!ok) text_valid = 1'b0;
      r.code_point  = cp;
      r.code_valid  = ok;
      r.seq_length  = len;
      r.last_result = 1'b0;
      r.text_end    = ends;
      r.text_ok     = text_valid;
      byte_results.push_back(r);
    endfunction

    function void flush_held(logic ends);
      repeat (held_cnt) emit(REPL_CP, 1'b0, 3'd1, ends);
      held_cnt     = '0;
      seq_len      = '0;
      partial_bits = '0;
    endfunction

    function void decode_lead(logic [7:0] b, logic ends);
      if (b < ASCII_TOP) begin
        emit(21'(b), 1'b1, 3'd1, ends);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        partial_bits = 21'(b & BITS2_MASK);
        held_cnt     = 3'd1;
        seq_len      = 3'd2;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        partial_bits = 21'(b & BITS3_MASK);
        held_cnt     = 3'd1;
        seq_len      = 3'd3;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        partial_bits = 21'(b & BITS4_MASK);
        held_cnt     = 3'd1;
        seq_len      = 3'd4;
      end else begin
        emit(REPL_CP, 1'b0, 3'd1, ends);
      end
    endfunction

    // one accepted input transfer: queue up every result it causes
    function void note_byte(logic [7:0] b, logic ends);
      byte_results.delete();
      if (held_cnt != 0) begin
        if ((b & CONT_MASK) == CONT_CODE) begin
          partial_bits = (partial_bits << 6) | 21'(b & CONT_BITS);
          held_cnt++;
          if (held_cnt >= seq_len) begin
            emit(partial_bits, 1'b1, seq_len, ends);
            held_cnt     = '0;
            seq_len      = '0;
            partial_bits = '0;
          end
        end else begin
          flush_held(ends);
          decode_lead(b, ends);
        end
      end else begin
        decode_lead(b, ends);
      end
      if (ends) begin
        flush_held(ends);
        text_valid = 1'b1;
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_result = 1'b1;
      foreach (byte_results[i]) expected_q.push_back(byte_results[i]);
    endfunction

    function void check_result(utf8_result_t got);
      utf8_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result cp=%06h ok=%0d len=%0d last=%0d end=%0d text_ok=%0d",
                   $realtime, got.code_point, got.code_valid, got.seq_length,
                   got.last_result, got.text_end, got.text_ok);
        return;
      end
      want = expected_q.pop_front();
      if (got.code_point !== want.code_point || got.code_valid !== want.code_valid ||
          got.seq_length !== want.seq_length || got.last_result !== want.last_result ||
          got.text_end !== want.text_end || got.text_ok !== want.text_ok) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected cp=%06h ok=%0d len=%0d last=%0d end=%0d text_ok=%0d",
                   want.code_point, want.code_valid, want.seq_length,
                   want.last_result, want.text_end, want.text_ok);
          $display("  actual   cp=%06h ok=%0d len=%0d last=%0d end=%0d text_ok=%0d",
                   got.code_point, got.code_valid, got.seq_length,
                   got.last_result, got.text_end, got.text_ok);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  utf8d_in_if  in_ch ();
  utf8d_out_if out_ch ();

  utf8_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_scoreboard sb;
  int unsigned    bytes_sent = 0;
  int unsigned    cycle_cnt = 0;
  bit             quiet_tx = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic ends);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= ends;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, ends);
    bytes_sent++;
    gap = quiet_tx ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // a text of random characters, mostly well formed, some broken
  task automatic send_random_text();
    logic [7:0]  text_q[$];
    logic [20:0] cp;
    int          n_chars;
    int          kind;
    int          seq_bytes;
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      cp   = 21'($urandom);
      if (kind < 30) begin
        text_q.push_back({1'b0, cp[6:0]});
      end else if (kind < 50) begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end else if (kind < 68) begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end else if (kind < 84) begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end else if (kind < 90) begin
        // truncated sequence
        seq_bytes = $urandom_range(2, 4);
        case (seq_bytes)
          2: text_q.push_back({3'b110, cp[4:0]});
          3: text_q.push_back({4'b1110, cp[3:0]});
          default: text_q.push_back({5'b11110, cp[2:0]});
        endcase
        repeat ($urandom_range(0, seq_bytes - 2)) text_q.push_back({2'b10, cp[20:15]});
      end else if (kind < 95) begin
        text_q.push_back({2'b10, cp[5:0]});
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // receiver: ready runs of random length broken by stalls
  initial begin
    int run;
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      gap = gap_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    utf8_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.code_point  = out_ch.code_point;
      got.code_valid  = out_ch.code_valid;
      got.seq_length  = out_ch.seq_length;
      got.last_result = out_ch.last_result;
      got.text_end    = out_ch.text_end;
      got.text_ok     = out_ch.text_ok;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
      quiet_tx = ($urandom_range(0, 5) == 0);
      send_random_text();
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
